// File: rtl/core/standardized_residual_filter_macros.svh
// Assertion macros for the standardized residual filter.
// Needs a clock named clk and a reset named rst in the including module.
`ifndef STANDARDIZED_RESIDUAL_FILTER_MACROS_SVH
`define STANDARDIZED_RESIDUAL_FILTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SRF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/srf_pkg.sv
// Types, constants and per-stage step functions of the standardized residual filter.
// No dependencies.
package srf_pkg;

  localparam int unsigned SQRT_STAGES = 32;
  localparam int unsigned DIV_STAGES  = 31;
  localparam logic [30:0] Q130_ONE    = 31'h4000_0000;

  // Square root phase: holds the remainder and partial root.
  typedef struct packed {
    logic [15:0] row;
    logic [11:0] col;
    logic [31:0] p;
    logic [63:0] e;
    logic [63:0] v;
    logic [63:0] res;
  } sq_t;

  // Divide phase: restoring division of (|a-e| + s) by 2s.
  typedef struct packed {
    logic [15:0] row;
    logic [11:0] col;
    logic        neg;
    logic        zero;
    logic        sat;
    logic [64:0] rem;
    logic [32:0] dvs;
    logic [30:0] q;
  } dv_t;

  // One pair of bits of the integer square root; k = 0 handles the top pair.
  function automatic sq_t sqrt_step(sq_t x, int unsigned k);
    sq_t         y;
    logic [63:0] bt;
    logic [63:0] trial;
    y     = x;
    bt    = 64'(1) << (62 - 2 * k);
    trial = x.res + bt;
    if (x.v >= trial) begin
      y.v   = x.v - trial;
      y.res = (x.res >> 1) + bt;
    end else begin
      y.res = x.res >> 1;
    end
    return y;
  endfunction

  // One quotient bit b of the restoring divider.
  function automatic dv_t div_step(dv_t x, int unsigned b);
    dv_t         y;
    logic [64:0] sh;
    y  = x;
    sh = 65'(x.dvs) << b;
    if (x.rem >= sh) begin
      y.rem  = x.rem - sh;
      y.q[b] = 1'b1;
    end
    return y;
  endfunction

endpackage

// File: rtl/core/standardized_residual_filter.sv
// Standardized residual filter: streams table cells, emits (p - r*c)/sqrt(r*c) above a floor.
// Depends on srf_pkg and standardized_residual_filter_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one cell per request: row_index,
//   col_index, cell_value p, row_mass r and col_mass c, all masses unsigned Q0.31.
//   Output channel (out_valid/out_ready) carries out_row, out_col and the signed
//   Q1.30 residual, only for cells whose residual magnitude exceeds the floor.
//   cfg_we/cfg_data write the 31-bit floor residual_threshold; write it only
//   while no request is in flight.
// Pipeline: multiply register loaded at the accepting edge, then 32 square-root stages,
//   1 setup stage, 31 divide stages and the output register.
//   Cells with r*c == 0 or small residuals leave no result.
// Throughput: one request per cycle while the skid register is empty; every stage
//   takes a new cell each cycle the pipe advances, one root bit or one quotient bit per stage.
// Stall: a one-entry skid register behind the output register catches the cell
//   in flight when the receiver holds off; while it is full the whole pipe holds
//   and in_ready drops. Nothing is lost or repeated.
// Reset: rst (synchronous, active high) clears all valid bits and sets the floor to 0.
`include "standardized_residual_filter_macros.svh"

module standardized_residual_filter (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic        [30:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [15:0] row_index,
  input  logic        [11:0] col_index,
  input  logic        [31:0] cell_value,
  input  logic        [31:0] row_mass,
  input  logic        [31:0] col_mass,
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [15:0] out_row,
  output logic        [11:0] out_col,
  output logic signed [31:0] residual
);

  logic [30:0] residual_threshold;

  // Pipeline storage; index 0 is the multiply stage / divider setup stage.
  srf_pkg::sq_t sq     [srf_pkg::SQRT_STAGES+1];
  logic         sq_vld [srf_pkg::SQRT_STAGES+1];
  srf_pkg::dv_t dv     [srf_pkg::DIV_STAGES+1];
  logic         dv_vld [srf_pkg::DIV_STAGES+1];

  logic        en;
  logic        emit;
  logic [30:0] mag;
  logic [31:0] word;

  logic               skid_valid;
  logic        [15:0] skid_row;
  logic        [11:0] skid_col;
  logic signed [31:0] skid_res;

  // Advance the whole pipe unless the skid register holds a cell.
  assign en       = !skid_valid;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      residual_threshold <= '0;
    end else if (cfg_we) begin
      residual_threshold <= cfg_data;
    end
  end

  // Multiply stage: expected mass e = r*c, seeded as the root remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (en) begin
      sq_vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].row <= row_index;
      sq[0].col <= col_index;
      sq[0].p   <= cell_value;
      sq[0].e   <= 64'(row_mass) * 64'(col_mass);
      sq[0].v   <= 64'(row_mass) * 64'(col_mass);
      sq[0].res <= '0;
    end
  end

  // Square root: one result bit per stage.
  for (genvar k = 0; k < srf_pkg::SQRT_STAGES; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (en) begin
        sq_vld[k+1] <= sq_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k+1] <= srf_pkg::sqrt_step(sq[k], k);
      end
    end
  end

  // Divider setup: d = |p*2^31 - e|, numerator d + s rounds to nearest,
  // divisor 2s; flag saturation when the quotient would reach 2^31.
  logic [63:0] su_a;
  logic [63:0] su_d;
  logic [31:0] su_s;
  logic [64:0] su_n;

  always_comb begin
    su_a = {1'b0, sq[srf_pkg::SQRT_STAGES].p, 31'b0};
    su_s = sq[srf_pkg::SQRT_STAGES].res[31:0];
    if (su_a >= sq[srf_pkg::SQRT_STAGES].e) begin
      su_d = su_a - sq[srf_pkg::SQRT_STAGES].e;
    end else begin
      su_d = sq[srf_pkg::SQRT_STAGES].e - su_a;
    end
    su_n = 65'(su_d) + 65'(su_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      dv_vld[0] <= sq_vld[srf_pkg::SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].row  <= sq[srf_pkg::SQRT_STAGES].row;
      dv[0].col  <= sq[srf_pkg::SQRT_STAGES].col;
      dv[0].neg  <= su_a < sq[srf_pkg::SQRT_STAGES].e;
      dv[0].zero <= sq[srf_pkg::SQRT_STAGES].e == 64'd0;
      dv[0].sat  <= su_n >= {1'b0, su_s, 32'b0};
      dv[0].rem  <= su_n;
      dv[0].dvs  <= {su_s, 1'b0};
      dv[0].q    <= '0;
    end
  end

  // Restoring divide: quotient bit 30 first.
  for (genvar j = 0; j < srf_pkg::DIV_STAGES; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j+1] <= 1'b0;
      end else if (en) begin
        dv_vld[j+1] <= dv_vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+1] <= srf_pkg::div_step(dv[j], srf_pkg::DIV_STAGES - 1 - j);
      end
    end
  end

  // Saturate to 1.0, apply the floor, drop zero-mass cells, apply sign.
  always_comb begin
    if (dv[srf_pkg::DIV_STAGES].sat || (dv[srf_pkg::DIV_STAGES].q > srf_pkg::Q130_ONE)) begin
      mag = srf_pkg::Q130_ONE;
    end else begin
      mag = dv[srf_pkg::DIV_STAGES].q;
    end
    word = dv[srf_pkg::DIV_STAGES].neg ? (32'd0 - 32'(mag)) : 32'(mag);
    emit = en && dv_vld[srf_pkg::DIV_STAGES] && !dv[srf_pkg::DIV_STAGES].zero &&
           (mag > residual_threshold);
  end

  // Output register with skid: drain the skid first, park a cell when held.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || emit;
      skid_valid <= 1'b0;
    end else if (emit) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_row  <= skid_row;
        out_col  <= skid_col;
        residual <= skid_res;
      end else begin
        out_row  <= dv[srf_pkg::DIV_STAGES].row;
        out_col  <= dv[srf_pkg::DIV_STAGES].col;
        residual <= $signed(word);
      end
    end else if (emit) begin
      skid_row <= dv[srf_pkg::DIV_STAGES].row;
      skid_col <= dv[srf_pkg::DIV_STAGES].col;
      skid_res <= $signed(word);
    end
  end

  `SRF_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid, "skid full with empty output")
  `SRF_ASSERT_IMP(a_res_range, out_valid,
    ($signed(residual) <= 32'sd1073741824) && ($signed(residual) >= -32'sd1073741824),
    "residual outside [-1, 1]")
  `SRF_ASSERT_IMP(a_res_nonzero, out_valid, residual != 32'd0, "zero residual emitted")
  `SRF_ASSERT_NXT(a_skid_fill, !skid_valid && !(out_valid && !out_ready), !skid_valid,
    "skid filled while output was free")

endmodule
